@@ src/jsu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and helpers for the JSON string unescaper
// Result kinds, error codes, escape and hex decoding, the result bundle.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int JSU_FIFO_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NO_QUOTE = 3'd0,
      ERR_CONTROL  = 3'd1,
      ERR_ESCAPE   = 3'd2,
      ERR_TRUNC_U  = 3'd3,
      ERR_HEX      = 3'd4,
      ERR_UNTERM   = 3'd5
   } err_type;

   // closing result of one input byte, after its data bytes
   typedef enum logic [1:0] {
      TAIL_NONE  = 2'd0,
      TAIL_DONE  = 2'd1,
      TAIL_ERROR = 2'd2
   } tail_type;

   // all results caused by one input byte
   typedef struct packed {
      logic [1:0]      data_n;
      logic [2:0][7:0] data;
      tail_type        tail;
      err_type         err;
   } bundle_type;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_U = 8'h75;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   // {valid, value} of one hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
         r = {1'b1, c[3:0] + 4'd9};
      return r;
   endfunction

   // {valid, byte} of a single-character escape
   function automatic logic [8:0] esc_map(input logic [7:0] c);
      logic [8:0] r;
      r = 9'd0;
      unique case (c)
         CH_QUOTE, CH_BSLASH, CH_SLASH: r = {1'b1, c};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

@@ src/jsu_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_req_if: input byte channel
// One text byte per beat, with its first-byte flag and remaining count.
// ----------------------------------------------------------------------------
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       first_byte;
   logic [2:0] bytes_after;

   modport source (output valid, output text_byte, output first_byte,
                   output bytes_after, input ready);
   modport sink (input valid, input text_byte, input first_byte,
                 input bytes_after, output ready);
endinterface

@@ src/jsu_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_rsp_if: result channel
// One decoded byte, completion or error per beat.
// ----------------------------------------------------------------------------
interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic [2:0] error_code;
   logic       last_result;

   modport source (output valid, output kind, output out_byte,
                   output error_code, output last_result, input ready);
   modport sink (input valid, input kind, input out_byte,
                 input error_code, input last_result, output ready);
endinterface

@@ src/json_string_unescape.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape: JSON string body to UTF-8 bytes
// Decodes escapes and \u sequences, one text byte per beat, and ends each
// string with a done or error result.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle unless the queue is full: the
// byte is decoded in the cycle it is accepted, and all results it causes
// (up to three data bytes, then an optional done or error) are written as
// one bundle into a FIFO_DEPTH-entry result queue. While rsp ready is high
// the result side spends one cycle per result, so a byte that yields N
// results holds the queue head until all N are taken; plain text gives one
// result per byte and streams at one byte per cycle; the three-byte UTF-8
// forms of \u escapes are absorbed by the queue. req ready drops only when
// the queue is full. Bytes that cause no result (idle bytes, the backslash,
// the 'u' and the hex digits before the last one) never occupy the queue.
// ----------------------------------------------------------------------------
module json_string_unescape
   import jsu_pkg::*;
#(
   parameter int FIFO_DEPTH = JSU_FIFO_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   jsu_req_if.sink   req_bus,
   jsu_rsp_if.source rsp_bus
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_BODY = 3'd1,
      PH_ESC  = 3'd2,
      PH_HEX0 = 3'd3,
      PH_HEX1 = 3'd4,
      PH_HEX2 = 3'd5,
      PH_HEX3 = 3'd6
   } phase_type;

   // decoder state: where we are in the string and the hex digits so far
   phase_type   phase_ff, phase_in;
   logic [11:0] cp_ff, cp_in;

   // result queue, one bundle per input byte that has results
   bundle_type             mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [1:0]             sub_ff, sub_in;

   bundle_type  bundle;
   logic        req_fire;
   logic        push;
   logic        pop;
   logic        end_of_text;
   logic        short_u;
   logic [4:0]  hex;
   logic [8:0]  esc;
   logic [15:0] cp16;
   logic [7:0]  c;

   bundle_type  head;
   logic [2:0]  head_total;
   logic        head_last;

   assign req_bus.ready = (count_ff != CNT_W'(FIFO_DEPTH));
   assign req_fire      = req_bus.valid & req_bus.ready;

   assign c           = req_bus.text_byte;
   assign end_of_text = (req_bus.bytes_after == 3'd0);
   // only bytes_after counts 0..3 are short
   assign short_u     = (req_bus.bytes_after < 3'd4);
   assign hex         = hex_digit(c);
   assign esc         = esc_map(c);
   assign cp16        = {cp_ff, hex[3:0]};

   // Decode the offered byte against the current phase. Results land in
   // bundle; the next phase and digit accumulator in phase_in / cp_in.
   always_comb begin
      bundle      = '0;
      bundle.tail = TAIL_NONE;
      bundle.err  = ERR_NO_QUOTE;
      phase_in    = phase_ff;
      cp_in       = cp_ff;

      if (req_bus.first_byte) begin
         // restart: drop any open string
         if (c != CH_QUOTE) begin
            bundle.tail = TAIL_ERROR;
            bundle.err  = ERR_NO_QUOTE;
            phase_in    = PH_IDLE;
         end else begin
            phase_in = PH_BODY;
            if (end_of_text) begin
               bundle.tail = TAIL_ERROR;
               bundle.err  = ERR_UNTERM;
               phase_in    = PH_IDLE;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_BODY: begin
               priority if (c == 8'h00) begin
                  // NUL ends the text
                  bundle.tail = TAIL_ERROR;
                  bundle.err  = ERR_UNTERM;
                  phase_in    = PH_IDLE;
               end else if (c == CH_QUOTE) begin
                  bundle.tail = TAIL_DONE;
                  phase_in    = PH_IDLE;
               end else if (c < CTRL_LIMIT) begin
                  bundle.tail = TAIL_ERROR;
                  bundle.err  = ERR_CONTROL;
                  phase_in    = PH_IDLE;
               end else if (c == CH_BSLASH) begin
                  if (end_of_text) begin
                     bundle.tail = TAIL_ERROR;
                     bundle.err  = ERR_ESCAPE;
                     phase_in    = PH_IDLE;
                  end else begin
                     phase_in = PH_ESC;
                  end
               end else begin
                  bundle.data_n  = 2'd1;
                  bundle.data[0] = c;
                  if (end_of_text) begin
                     bundle.tail = TAIL_ERROR;
                     bundle.err  = ERR_UNTERM;
                     phase_in    = PH_IDLE;
                  end
               end
            end
            PH_ESC: begin
               priority if (esc[8]) begin
                  bundle.data_n  = 2'd1;
                  bundle.data[0] = esc[7:0];
                  phase_in       = PH_BODY;
                  if (end_of_text) begin
                     bundle.tail = TAIL_ERROR;
                     bundle.err  = ERR_UNTERM;
                     phase_in    = PH_IDLE;
                  end
               end else if (c == CH_U) begin
                  if (short_u) begin
                     bundle.tail = TAIL_ERROR;
                     bundle.err  = ERR_TRUNC_U;
                     phase_in    = PH_IDLE;
                  end else begin
                     cp_in    = '0;
                     phase_in = PH_HEX0;
                  end
               end else begin
                  bundle.tail = TAIL_ERROR;
                  bundle.err  = ERR_ESCAPE;
                  phase_in    = PH_IDLE;
               end
            end
            PH_HEX0, PH_HEX1, PH_HEX2: begin
               if (!hex[4]) begin
                  bundle.tail = TAIL_ERROR;
                  bundle.err  = ERR_HEX;
                  phase_in    = PH_IDLE;
               end else begin
                  cp_in    = cp16[11:0];
                  phase_in = phase_type'(phase_ff + 3'd1);
               end
            end
            PH_HEX3: begin
               if (!hex[4]) begin
                  bundle.tail = TAIL_ERROR;
                  bundle.err  = ERR_HEX;
                  phase_in    = PH_IDLE;
               end else begin
                  // encode the code point as UTF-8, surrogates unpaired
                  priority if (cp16 <= 16'h007F) begin
                     bundle.data_n  = 2'd1;
                     bundle.data[0] = cp16[7:0];
                  end else if (cp16 <= 16'h07FF) begin
                     bundle.data_n  = 2'd2;
                     bundle.data[0] = 8'hC0 | {3'b000, cp16[10:6]};
                     bundle.data[1] = 8'h80 | {2'b00, cp16[5:0]};
                  end else begin
                     bundle.data_n  = 2'd3;
                     bundle.data[0] = 8'hE0 | {4'b0000, cp16[15:12]};
                     bundle.data[1] = 8'h80 | {2'b00, cp16[11:6]};
                     bundle.data[2] = 8'h80 | {2'b00, cp16[5:0]};
                  end
                  phase_in = PH_BODY;
                  if (end_of_text) begin
                     bundle.tail = TAIL_ERROR;
                     bundle.err  = ERR_UNTERM;
                     phase_in    = PH_IDLE;
                  end
               end
            end
            default: begin
               // idle, and the unreachable phase code: ignore the byte
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // queue only bytes that produce at least one result
   assign push = req_fire && ((bundle.data_n != 2'd0) || (bundle.tail != TAIL_NONE));

   // present the queue head one result per beat
   assign head       = mem_ff[rd_ptr_ff];
   assign head_total = {1'b0, head.data_n} + ((head.tail != TAIL_NONE) ? 3'd1 : 3'd0);
   assign head_last  = (({1'b0, sub_ff} + 3'd1) == head_total);

   assign rsp_bus.valid = (count_ff != '0);
   assign pop           = rsp_bus.valid & rsp_bus.ready & head_last;

   always_comb begin
      if ({1'b0, sub_ff} < {1'b0, head.data_n}) begin
         rsp_bus.kind       = KIND_DATA;
         rsp_bus.out_byte   = head.data[sub_ff];
         rsp_bus.error_code = 3'd0;
      end else if (head.tail == TAIL_DONE) begin
         rsp_bus.kind       = KIND_DONE;
         rsp_bus.out_byte   = 8'd0;
         rsp_bus.error_code = 3'd0;
      end else begin
         rsp_bus.kind       = KIND_ERROR;
         rsp_bus.out_byte   = 8'd0;
         rsp_bus.error_code = head.err;
      end
   end
   assign rsp_bus.last_result = head_last;

   // pointer, count and sub-result bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      sub_in    = sub_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
         if (head_last) begin
            rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
            sub_in    = 2'd0;
         end else begin
            sub_in = sub_ff + 2'd1;
         end
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         cp_ff     <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= 2'd0;
      end else begin
         if (req_fire) begin
            phase_ff <= phase_in;
            cp_ff    <= cp_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

   // queue storage: write the bundle of the accepted byte
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= bundle;
      end
   end

endmodule
